// ----- src/fr_pkg.sv -----
// ----------------------------------------------------------------------------
// fr_pkg
// Shared widths, beat types and control/status bundles for the fraction
// reducer.
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int VALUE_WIDTH = 16;
  // Holds a shift count or a bit index, both at most VALUE_WIDTH-1.
  localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    value_t numerator;
    value_t denominator;
  } in_beat_t;

  typedef struct packed {
    value_t reduced_numerator;
    value_t reduced_denominator;
    logic   was_reducible;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic result_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic zero_in;
    logic gcd_done;
    logic g_is_one;
    logic div_last;
  } ctrl_status_t;

endpackage

// ----- src/fr_datapath.sv -----
// ----------------------------------------------------------------------------
// fr_datapath
// Binary gcd unit, two restoring dividers sharing the gcd as divisor, and
// the result register.
// ----------------------------------------------------------------------------
module fr_datapath (
  input  logic                 clk,
  input  fr_pkg::in_beat_t     in_data,
  input  fr_pkg::ctrl_cmd_t    cmd,
  output fr_pkg::ctrl_status_t status,
  output fr_pkg::out_beat_t    out_data
);

  localparam int W = fr_pkg::VALUE_WIDTH;
  localparam int C = fr_pkg::CNT_W;

  fr_pkg::value_t orig_num;
  fr_pkg::value_t orig_den;
  fr_pkg::value_t a;
  fr_pkg::value_t b;
  logic [C-1:0]   k;
  fr_pkg::value_t g;
  fr_pkg::value_t rem_n;
  fr_pkg::value_t rem_d;
  fr_pkg::value_t quo_n;
  fr_pkg::value_t quo_d;
  logic [C-1:0]   count;
  logic           reducible;

  logic [W:0]     shift_n;
  logic [W:0]     shift_d;
  logic           fit_n;
  logic           fit_d;
  logic [W:0]     sub_n;
  logic [W:0]     sub_d;
  logic           a_gt_b;

  assign a_gt_b  = a > b;
  assign shift_n = {rem_n, quo_n[W-1]};
  assign shift_d = {rem_d, quo_d[W-1]};
  assign fit_n   = shift_n >= {1'b0, g};
  assign fit_d   = shift_d >= {1'b0, g};
  assign sub_n   = shift_n - {1'b0, g};
  assign sub_d   = shift_d - {1'b0, g};

  assign status.zero_in  = (orig_num == '0) || (orig_den == '0);
  assign status.gcd_done = (a == b);
  assign status.g_is_one = (a == b) && (a == fr_pkg::value_t'(1)) && (k == '0);
  assign status.div_last = (count == C'(W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      orig_num  <= in_data.numerator;
      orig_den  <= in_data.denominator;
      a         <= in_data.numerator;
      b         <= in_data.denominator;
      k         <= '0;
      reducible <= 1'b0;
    end

    if (cmd.gcd_step) begin
      priority if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + C'(1);
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a_gt_b) begin
        a <= (a - b) >> 1;
      end else begin
        b <= (b - a) >> 1;
      end
    end

    if (cmd.div_init) begin
      g         <= a << k;
      rem_n     <= '0;
      rem_d     <= '0;
      quo_n     <= orig_num;
      quo_d     <= orig_den;
      count     <= '0;
      reducible <= 1'b1;
    end

    if (cmd.div_step) begin
      // remainder stays below g, so the low W bits carry it
      rem_n <= fit_n ? sub_n[W-1:0] : shift_n[W-1:0];
      rem_d <= fit_d ? sub_d[W-1:0] : shift_d[W-1:0];
      quo_n <= {quo_n[W-2:0], fit_n};
      quo_d <= {quo_d[W-2:0], fit_d};
      count <= count + C'(1);
    end

    if (cmd.result_write) begin
      out_data.reduced_numerator   <= reducible ? quo_n : orig_num;
      out_data.reduced_denominator <= reducible ? quo_d : orig_den;
      out_data.was_reducible       <= reducible;
    end
  end

endmodule

// ----- src/fr_controller.sv -----
// ----------------------------------------------------------------------------
// fr_controller
// Sequences load, gcd iterations, division and result hand-off; owns the
// input ready and the output valid.
// ----------------------------------------------------------------------------
module fr_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fr_pkg::ctrl_status_t status,
  output fr_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GCD,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        // zero operand or coprime: pass the inputs through
        priority if (status.zero_in || status.g_is_one) begin
          state_next = S_FINISH;
        end else if (status.gcd_done) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.result_write = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_valid_next = (out_valid && !out_ready) || cmd.result_write;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- src/fraction_reducer_top.sv -----
// ----------------------------------------------------------------------------
// fraction_reducer_top
// Reduces a fraction to lowest terms by binary gcd and restoring division.
// ----------------------------------------------------------------------------
//  channel | handshake              | beat type
//  --------+------------------------+--------------------
//  input   | in_valid / in_ready    | fr_pkg::in_beat_t
//  output  | out_valid / out_ready  | fr_pkg::out_beat_t
//
// One beat at a time. Steps per beat: a load, gcd iterations (one shift
// or subtract each), a decision step, one divider step per quotient bit
// and a write; coprime or zero inputs skip the divider. Reset clears only
// control state. The output register holds a finished beat while the
// next one is being worked on; the write waits while that beat is still
// unaccepted.
// ----------------------------------------------------------------------------
module fraction_reducer_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fr_pkg::in_beat_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fr_pkg::out_beat_t out_data
);

  fr_pkg::ctrl_cmd_t    cmd;
  fr_pkg::ctrl_status_t status;

  fr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fr_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
